// ----- rtl/core/lfps_pkg.sv -----
`timescale 1ns / 1ps

package lfps_pkg;

   // Field widths fixed by the stream formats.
   localparam int SENSOR_W  = 5;
   localparam int GAIN_W    = 16;
   localparam int BASE_W    = 7;
   localparam int DUTY_W    = 10;
   localparam int ERR_W     = 13;
   localparam int MUL_A_W   = 14;
   localparam int MUL_B_W   = GAIN_W + 1;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W     = 32;
   localparam int CORR_W    = 18;
   localparam int SPEED_W   = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = GAIN_W;

   localparam int LFPS_PWM_SCALE_DEFAULT = 10;

   localparam logic [GAIN_W-1:0] KP_RESET   = 16'd459;
   localparam logic [GAIN_W-1:0] KI_RESET   = 16'd0;
   localparam logic [GAIN_W-1:0] KD_RESET   = 16'd197;
   localparam logic [BASE_W-1:0] BASE_RESET = 7'd25;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_KP_GAIN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI_GAIN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD_GAIN    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPEED = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACC,
      ST_SPEED,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_SEL_P,
      MUL_SEL_I,
      MUL_SEL_D
   } mul_sel_type;

   typedef struct packed {
      logic        load_item;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_init;
      logic        acc_add;
      logic        speed_en;
      logic        out_load;
   } dp_cmd_type;

   // Setpoint minus the truncated centroid of the active sensors.
   // The all-clear pattern carries no centroid and returns zero.
   function automatic logic signed [ERR_W-1:0] centroid_error(
      input logic [SENSOR_W-1:0] bits
   );
      logic signed [ERR_W-1:0] e;
      case (bits)
         5'd1:    e = 13'sd2000;
         5'd2:    e = 13'sd500;
         5'd3:    e = 13'sd1250;
         5'd4:    e = 13'sd0;
         5'd5:    e = 13'sd1000;
         5'd6:    e = 13'sd250;
         5'd7:    e = 13'sd834;
         5'd8:    e = -13'sd500;
         5'd9:    e = 13'sd750;
         5'd10:   e = 13'sd0;
         5'd11:   e = 13'sd667;
         5'd12:   e = -13'sd250;
         5'd13:   e = 13'sd500;
         5'd14:   e = 13'sd0;
         5'd15:   e = 13'sd500;
         5'd16:   e = -13'sd2000;
         5'd17:   e = 13'sd0;
         5'd18:   e = -13'sd750;
         5'd19:   e = 13'sd167;
         5'd20:   e = -13'sd1000;
         5'd21:   e = 13'sd0;
         5'd22:   e = -13'sd500;
         5'd23:   e = 13'sd125;
         5'd24:   e = -13'sd1250;
         5'd25:   e = -13'sd166;
         5'd26:   e = -13'sd666;
         5'd27:   e = 13'sd0;
         5'd28:   e = -13'sd833;
         5'd29:   e = -13'sd125;
         5'd30:   e = -13'sd500;
         5'd31:   e = 13'sd0;
         default: e = 13'sd0;
      endcase
      return e;
   endfunction

   // Saturates a wheel speed to the range -100..+100.
   function automatic logic signed [SPEED_W-1:0] clamp_speed(
      input logic signed [CORR_W-1:0] v
   );
      logic signed [SPEED_W-1:0] s;
      if (v > 18'sd100) begin
         s = 8'sd100;
      end else if (v < -18'sd100) begin
         s = -8'sd100;
      end else begin
         s = v[SPEED_W-1:0];
      end
      return s;
   endfunction

endpackage

// ----- rtl/core/lfps_ctrl.sv -----
`timescale 1ns / 1ps

module lfps_ctrl import lfps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_SEL_P;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SEL_P;
            state_in    = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_SEL_I;
            cmd.acc_init = 1'b1;
            state_in     = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SEL_D;
            cmd.acc_add = 1'b1;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_add = 1'b1;
            state_in    = ST_SPEED;
         end
         ST_SPEED: begin
            cmd.speed_en = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            // The result register may still hold the previous transfer.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- rtl/core/lfps_dp.sv -----
`timescale 1ns / 1ps

module lfps_dp import lfps_pkg::*; #(
   parameter int PWM_SCALE = LFPS_PWM_SCALE_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  logic [SENSOR_W-1:0]   sensor_bits,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [DUTY_W-1:0]     left_fwd_duty,
   output logic [DUTY_W-1:0]     left_rev_duty,
   output logic [DUTY_W-1:0]     right_fwd_duty,
   output logic [DUTY_W-1:0]     right_rev_duty,
   output logic                  line_lost
);

   // Configuration registers.
   logic [GAIN_W-1:0] kp_ff, ki_ff, kd_ff;
   logic [BASE_W-1:0] base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff   <= KP_RESET;
         ki_ff   <= KI_RESET;
         kd_ff   <= KD_RESET;
         base_ff <= BASE_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_KP_GAIN:    kp_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_KI_GAIN:    ki_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_KD_GAIN:    kd_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_BASE_SPEED: base_ff <= csr_wdata[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   // Item capture and steering state.
   logic signed [ERR_W-1:0] err_ff, prev_err_ff;
   logic                    lost_ff;
   logic                    side_right_ff, side_right_in;

   always_comb begin
      side_right_in = side_right_ff;
      if (sensor_bits[0]) begin
         side_right_in = 1'b1;
      end
      if (sensor_bits[SENSOR_W-1]) begin
         side_right_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_right_ff <= 1'b0;
         prev_err_ff   <= '0;
      end else begin
         if (cmd.load_item) begin
            side_right_ff <= side_right_in;
         end
         if (cmd.out_load && !lost_ff) begin
            prev_err_ff <= err_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         err_ff  <= centroid_error(sensor_bits);
         lost_ff <= (sensor_bits == '0);
      end
   end

   // Shared multiplier with a product register, then the accumulator.
   logic signed [MUL_A_W-1:0] err_x, prev_x, abs_err, abs_prev;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in, prod_x;

   assign err_x    = {err_ff[ERR_W-1], err_ff};
   assign prev_x   = {prev_err_ff[ERR_W-1], prev_err_ff};
   assign abs_err  = err_x[MUL_A_W-1] ? -err_x : err_x;
   assign abs_prev = prev_x[MUL_A_W-1] ? -prev_x : prev_x;

   always_comb begin
      case (cmd.mul_sel)
         MUL_SEL_P: begin
            mul_a = err_x;
            mul_b = {1'b0, kp_ff};
         end
         MUL_SEL_I: begin
            mul_a = abs_err + abs_prev;
            mul_b = {1'b0, ki_ff};
         end
         MUL_SEL_D: begin
            // The derivative term is subtracted, so feed its negation.
            mul_a = prev_x - err_x;
            mul_b = {1'b0, kd_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign prod_x  = {prod_ff[PROD_W-1], prod_ff};

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_init) begin
         acc_in = prod_x;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + prod_x;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   // Correction truncated toward zero, wheel speeds and saturation.
   logic [ACC_W-1:0]          acc_mag;
   logic [GAIN_W-1:0]         corr_mag;
   logic signed [CORR_W-1:0]  corr, base_x, left_raw, right_raw;
   logic signed [SPEED_W-1:0] spin, left_speed_ff, right_speed_ff;
   logic signed [SPEED_W-1:0] left_speed_in, right_speed_in;

   assign acc_mag  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign corr_mag = acc_mag[ACC_W-1 -: GAIN_W];
   assign corr     = acc_ff[ACC_W-1] ? -$signed({2'b00, corr_mag})
                                     : $signed({2'b00, corr_mag});
   assign base_x    = $signed({{(CORR_W-BASE_W){1'b0}}, base_ff});
   assign left_raw  = base_x - corr;
   assign right_raw = base_x + corr;
   assign spin      = clamp_speed(base_x);

   always_comb begin
      if (lost_ff) begin
         left_speed_in  = side_right_ff ? -spin : spin;
         right_speed_in = side_right_ff ? spin : -spin;
      end else begin
         left_speed_in  = clamp_speed(left_raw);
         right_speed_in = clamp_speed(right_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.speed_en) begin
         left_speed_ff  <= left_speed_in;
         right_speed_ff <= right_speed_in;
      end
   end

   // Duty split by sign and scaling.
   logic [SPEED_W-1:0] left_mag, right_mag;
   logic [DUTY_W-1:0]  left_duty, right_duty;
   logic [DUTY_W-1:0]  left_fwd_ff, left_rev_ff, right_fwd_ff, right_rev_ff;
   logic               lost_out_ff;

   assign left_mag   = left_speed_ff[SPEED_W-1] ? SPEED_W'(-left_speed_ff)
                                                : SPEED_W'(left_speed_ff);
   assign right_mag  = right_speed_ff[SPEED_W-1] ? SPEED_W'(-right_speed_ff)
                                                 : SPEED_W'(right_speed_ff);
   assign left_duty  = DUTY_W'(left_mag) * DUTY_W'(PWM_SCALE);
   assign right_duty = DUTY_W'(right_mag) * DUTY_W'(PWM_SCALE);

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         left_fwd_ff  <= (left_speed_ff > 8'sd0) ? left_duty : '0;
         left_rev_ff  <= (left_speed_ff < 8'sd0) ? left_duty : '0;
         right_fwd_ff <= (right_speed_ff > 8'sd0) ? right_duty : '0;
         right_rev_ff <= (right_speed_ff < 8'sd0) ? right_duty : '0;
         lost_out_ff  <= lost_ff;
      end
   end

   assign left_fwd_duty  = left_fwd_ff;
   assign left_rev_duty  = left_rev_ff;
   assign right_fwd_duty = right_fwd_ff;
   assign right_rev_duty = right_rev_ff;
   assign line_lost      = lost_out_ff;

endmodule

// ----- rtl/core/line_follower_pd_steering.sv -----
`timescale 1ns / 1ps

// Line-follower steering controller. Each transfer on the req_ channel carries
// one sample of the five line sensors; each transfer on the rsp_ channel
// carries the four wheel PWM compare values for that sample and a flag that
// is set when no sensor saw the line. Exactly one result follows each sample.
// Gains and the base speed are written through the csr_ port, and the user
// must write them only while the block is idle; the block itself does not
// enforce this. A write takes effect at the clock edge where csr_wen is high.
// For an accepted sample the error is looked up at the accepting edge itself,
// then come three passes through the single shared multiplier for the
// proportional, summed-error and derivative terms, then the accumulation is
// finished, the wheel speeds are registered and the result register is loaded.
// The block is ready for a new sample in the cycle after the result is
// loaded, so it does not take a new sample before it is through with the last.
// If the receiver stalls, the finished result waits in the output register
// while the next sample is still accepted and worked on; that sample then
// waits until the output register is free.
// Reset is synchronous: it restores the register defaults, clears the stored
// previous error and the last-seen side, and empties the output register.
module line_follower_pd_steering import lfps_pkg::*; #(
   parameter int PWM_SCALE = LFPS_PWM_SCALE_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // Sample channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [4:0] sensor_bits, [7:5] zero
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,   // [9:0] left_fwd_duty,
                                              // [19:10] left_rev_duty,
                                              // [29:20] right_fwd_duty,
                                              // [39:30] right_rev_duty
   output logic                  rsp_tuser,   // [0] line_lost
   // Configuration write port.
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type         cmd;
   logic [DUTY_W-1:0]  left_fwd_duty, left_rev_duty;
   logic [DUTY_W-1:0]  right_fwd_duty, right_rev_duty;
   logic               line_lost;

   // The sequencer issues one command word per cycle to the datapath.
   lfps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   lfps_dp #(
      .PWM_SCALE (PWM_SCALE)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sensor_bits    (req_tdata[SENSOR_W-1:0]),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .left_fwd_duty  (left_fwd_duty),
      .left_rev_duty  (left_rev_duty),
      .right_fwd_duty (right_fwd_duty),
      .right_rev_duty (right_rev_duty),
      .line_lost      (line_lost)
   );

   // Result fields packed from the lowest bit up.
   assign rsp_tdata = {right_rev_duty, right_fwd_duty, left_rev_duty, left_fwd_duty};
   assign rsp_tuser = line_lost;

endmodule
